/* sv/phc_pkg.sv */
// ----------------------------------------------------------------------------
// phc_pkg: shared types, constants and function of the column packer
// Column record, directory base code and the nozzle spreading function.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int unsigned WORD_W          = 16;
    localparam int unsigned NOZZLE_W        = 8;
    localparam int unsigned MAX_GROUPS      = 13;
    localparam int unsigned LOW_W           = 48;
    localparam int unsigned HIGH_W          = 56;
    localparam int unsigned GROUP_COUNT_DEF = 13;
    localparam int unsigned DIR_TAG_BIT     = 13;

    localparam logic [WORD_W-1:0] DIR_BASE = 16'h2000;

    typedef struct packed {
        logic [HIGH_W-1:0] groups_high;
        logic [LOW_W-1:0]  groups_low;
        logic              odd_phase;
    } t_col;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] dir;
    } t_load_req;

    function automatic logic [WORD_W-1:0] spread_bits(
        input logic [NOZZLE_W-1:0] nozzles,
        input logic                phase
    );
        logic [WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < NOZZLE_W; k++) begin
            w[WORD_W-1-2*k] = nozzles[k];
        end
        return phase ? (w >> 1) : w;
    endfunction

endpackage

/* sv/phc_if.sv */
// ----------------------------------------------------------------------------
// phc_if: valid/ready channels of the column packer
// Column channel into the block and word channel out of it.
// ----------------------------------------------------------------------------
interface phc_col_if
    import phc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  groups_low;
    logic [HIGH_W-1:0] groups_high;
    logic              odd_phase;

    modport source (output valid, output groups_low, output groups_high,
                    output odd_phase, input ready);
    modport sink   (input valid, input groups_low, input groups_high,
                    input odd_phase, output ready);
endinterface

interface phc_word_if
    import phc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              last_word;

    modport source (output valid, output out_word, output last_word, input ready);
    modport sink   (input valid, input out_word, input last_word, output ready);
endinterface

/* sv/phc_spread.sv */
// ----------------------------------------------------------------------------
// phc_spread: group split, word spreading and directory build
// Turns one registered column into its group words, occupancy and directory.
// ----------------------------------------------------------------------------
module phc_spread
    import phc_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  t_col              i_col,
    output logic [WORD_W-1:0] o_words [GROUP_COUNT],
    output logic [GROUP_COUNT-1:0] o_nonempty,
    output logic [WORD_W-1:0] o_dir
);

    logic [LOW_W+HIGH_W-1:0] all_bits;

    assign all_bits = {i_col.groups_high, i_col.groups_low};

    always_comb begin
        o_dir = DIR_BASE;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            o_nonempty[g] = |all_bits[NOZZLE_W*g +: NOZZLE_W];
            o_words[g]    = spread_bits(all_bits[NOZZLE_W*g +: NOZZLE_W], i_col.odd_phase);
            o_dir[g]      = ~o_nonempty[g];
        end
    end

endmodule

/* sv/phc_emit.sv */
// ----------------------------------------------------------------------------
// phc_emit: word sequencer and output register
// Holds one column's words and sends the directory, then each non-empty word.
// ----------------------------------------------------------------------------
module phc_emit
    import phc_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_load_req              i_req,
    input  logic [WORD_W-1:0]      i_words [GROUP_COUNT],
    input  logic [GROUP_COUNT-1:0] i_nonempty,
    output logic                   o_take,
    phc_word_if.source             o_word
);

    logic                   r_busy;
    logic                   r_dir_pend;
    logic [GROUP_COUNT-1:0] r_mask;
    logic [WORD_W-1:0]      r_dir;
    logic [WORD_W-1:0]      r_words [GROUP_COUNT];
    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_out_word;
    logic                   r_out_last;

    logic                   out_adv;
    logic                   emit_fire;
    logic                   emit_last;
    logic [GROUP_COUNT-1:0] cur_onehot;
    logic [WORD_W-1:0]      sel_word;

    assign out_adv    = !r_out_valid || o_word.ready;
    assign emit_fire  = out_adv && r_busy;
    assign cur_onehot = r_mask & (~r_mask + GROUP_COUNT'(1));
    assign emit_last  = r_dir_pend ? (r_mask == '0) : ((r_mask & ~cur_onehot) == '0);
    assign o_take     = i_req.valid && (!r_busy || (emit_fire && emit_last));

    always_comb begin
        sel_word = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            sel_word = sel_word | (cur_onehot[g] ? r_words[g] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_dir_pend <= 1'b0;
        end else if (o_take) begin
            r_busy     <= 1'b1;
            r_dir_pend <= 1'b1;
        end else if (emit_fire) begin
            if (emit_last) begin
                r_busy <= 1'b0;
            end
            r_dir_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mask  <= i_nonempty;
            r_dir   <= i_req.dir;
            r_words <= i_words;
        end else if (emit_fire && !r_dir_pend) begin
            r_mask <= r_mask & ~cur_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_word <= r_dir_pend ? r_dir : sel_word;
            r_out_last <= emit_last;
        end
    end

    assign o_word.valid     = r_out_valid;
    assign o_word.out_word  = r_out_word;
    assign o_word.last_word = r_out_last;

`ifndef SYNTHESIS
    a_dir_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir_pend |-> r_busy)
        else $error("directory pending without an active column");

    a_dir_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_dir_pend |-> r_dir[DIR_TAG_BIT])
        else $error("directory word lacks its tag bit");

    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_dir_pend |-> r_mask != '0)
        else $error("active column has no group words left");

    a_group_word_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && !r_dir_pend |=> r_out_word != '0)
        else $error("empty group word sent");
`endif

endmodule

/* sv/printhead_column_packer.sv */
// ----------------------------------------------------------------------------
// printhead_column_packer: packs printhead columns into directory and words
// Input register, spreading logic and a word sequencer with output register.
// ----------------------------------------------------------------------------
// Usage:
//   i_col carries one column per transfer: 13 groups of 8 nozzle bits and
//   the odd_phase bit. o_word carries 16-bit words; each column yields a
//   directory word (0x2000 plus one bit per empty group) followed by the
//   spread word of every non-empty group, last_word marking the final one.
//   Path: a column is captured in the input register, then loaded into the
//   sequencer, and its words pass the output register, directory word first.
//   Throughput: one word per cycle on o_word while o_word.ready is high; a
//   column yields 1 + N words, N being its non-empty group count, so up to
//   14 words per column. The single output channel sets that rate. The next
//   column is loaded in the cycle its predecessor's last word enters the
//   output register, and one more column waits in the input register meanwhile.
//   Stall: when o_word.ready is low the output register holds a valid word,
//   the sequencer holds, and i_col.ready drops once the input register fills.
//   Reset: synchronous, active low; clears all valid and busy flags, so no
//   word is pending afterwards.
// ----------------------------------------------------------------------------
module printhead_column_packer
    import phc_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    phc_col_if.sink    i_col,
    phc_word_if.source o_word
);

    t_col                   r_col;
    logic                   r_col_valid;
    logic                   in_fire;
    logic                   take;
    t_load_req              req;
    logic [WORD_W-1:0]      words [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] nonempty;
    logic [WORD_W-1:0]      dir;

    assign i_col.ready = !r_col_valid || take;
    assign in_fire     = i_col.valid && i_col.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= 1'b0;
        end else if (in_fire) begin
            r_col_valid <= 1'b1;
        end else if (take) begin
            r_col_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_col.groups_low  <= i_col.groups_low;
            r_col.groups_high <= i_col.groups_high;
            r_col.odd_phase   <= i_col.odd_phase;
        end
    end

    phc_spread #(
        .GROUP_COUNT(GROUP_COUNT)
    ) u_spread (
        .i_col      (r_col),
        .o_words    (words),
        .o_nonempty (nonempty),
        .o_dir      (dir)
    );

    assign req.valid = r_col_valid;
    assign req.dir   = dir;

    phc_emit #(
        .GROUP_COUNT(GROUP_COUNT)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_words    (words),
        .i_nonempty (nonempty),
        .o_take     (take),
        .o_word     (o_word)
    );

endmodule
